[sv/cubic_wall_unit_normal_assert.svh]
// assertion macros for the wall unit normal block
// used by the top level; needs clk and arst_n in scope
`ifndef CUBIC_WALL_UNIT_NORMAL_ASSERT_SVH
`define CUBIC_WALL_UNIT_NORMAL_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CWUN_ASSERT_IMPL(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("cwun assertion failed");
`define CWUN_ASSERT_DELAY(label, cond, dly, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> ##(dly) (expr)) \
		else $error("cwun delayed assertion failed");
`else
`define CWUN_ASSERT_IMPL(label, cond, expr)
`define CWUN_ASSERT_DELAY(label, cond, dly, expr)
`endif
`endif

[sv/cwun_pkg.sv]
// widths, constants and the sideband type of the wall unit normal pipeline
// no dependencies
`timescale 1ns / 1ps
package cwun_pkg;
	localparam int COORD_WIDTH = 32;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int K_WIDTH = 16;
	localparam int OUT_WIDTH = 16;
	localparam int PT_W = COORD_WIDTH + 3;
	localparam int W_W = 36;
	localparam int LO_W = PT_W / 2;
	localparam int HI_W = PT_W - LO_W;
	localparam int LP_W = W_W + LO_W + 1;
	localparam int HP_W = W_W + HI_W;
	localparam int T_W = W_W + PT_W + 2;
	localparam int LIMB_BITS = 24;
	localparam int EXACT_BITS = 38;
	localparam int HI_T_W = T_W - LIMB_BITS;
	localparam int EX_W = (HI_T_W > EXACT_BITS + 1) ? HI_T_W : EXACT_BITS + 2;
	localparam int M_W = T_W;
	localparam int NM_W = 31;
	localparam int RS_STEPS = $clog2(M_W);
	localparam int LS_STEPS = $clog2(NM_W);
	localparam int STEP_SPLIT = 3;
	localparam int SQ_W = 2 * NM_W + 1;
	localparam int ISQ_ITERS = 32;
	localparam int ISQ_W = 2 * ISQ_ITERS;
	localparam int ISQ_PER_STAGE = 2;
	localparam int ISQ_STAGES = ISQ_ITERS / ISQ_PER_STAGE;
	localparam int ROOT_W = ISQ_ITERS;
	localparam int Q_W = NORMAL_FRAC_BITS + 2;
	localparam int NUM_W = NM_W + NORMAL_FRAC_BITS + 1;
	localparam int DIV_W = ROOT_W + Q_W;
	localparam int DIV_PER_STAGE = 2;
	localparam int DIV_STAGES = (Q_W + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
	localparam int O_W = (Q_W + 1 > OUT_WIDTH) ? Q_W + 1 : OUT_WIDTH;
	localparam int LATENCY = 13 + ISQ_STAGES + 1 + DIV_STAGES + 1;

	typedef struct packed {
		logic valid;
		logic zero;
		logic a_pos;
		logic b_neg;
		logic [NM_W-1:0] ma;
		logic [NM_W-1:0] mb;
	} cwun_side_t;
endpackage

[sv/cwun_isqrt_pipe.sv]
// pipelined integer square root, two result bits per stage
// depends on cwun_pkg
`timescale 1ns / 1ps
module cwun_isqrt_pipe (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [cwun_pkg::SQ_W-1:0]      x,
	input  cwun_pkg::cwun_side_t           side_in,
	output logic [cwun_pkg::ROOT_W-1:0]    root,
	output cwun_pkg::cwun_side_t           side_out
);
	localparam int XW = cwun_pkg::ISQ_W;
	localparam int NS = cwun_pkg::ISQ_STAGES;

	logic [XW-1:0] rem_s [NS];
	logic [XW-1:0] res_s [NS];
	cwun_pkg::cwun_side_t side_s [NS];
	logic [XW-1:0] rem_in [NS];
	logic [XW-1:0] res_in [NS];
	cwun_pkg::cwun_side_t sd_in [NS];
	logic [XW-1:0] rem_nx [NS];
	logic [XW-1:0] res_nx [NS];

	genvar g;
	for (g = 0; g < NS; g++) begin : g_stage
		if (g == 0) begin : g_first
			assign rem_in[g] = XW'(x);
			assign res_in[g] = '0;
			assign sd_in[g] = side_in;
		end else begin : g_next
			assign rem_in[g] = rem_s[g-1];
			assign res_in[g] = res_s[g-1];
			assign sd_in[g] = side_s[g-1];
		end

		always_comb begin
			logic [XW-1:0] r;
			logic [XW-1:0] q;
			logic [XW-1:0] b;
			logic [XW-1:0] t;
			r = rem_in[g];
			q = res_in[g];
			for (int i = 0; i < cwun_pkg::ISQ_PER_STAGE; i++) begin
				b = XW'(1) << (2 * (cwun_pkg::ISQ_ITERS - 1 - (g * cwun_pkg::ISQ_PER_STAGE + i)));
				t = q + b;
				if (r >= t) begin
					r = r - t;
					q = (q >> 1) + b;
				end else begin
					q = q >> 1;
				end
			end
			rem_nx[g] = r;
			res_nx[g] = q;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[g] <= '0;
			end else begin
				side_s[g] <= sd_in[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g] <= rem_nx[g];
			res_s[g] <= res_nx[g];
		end
	end

	assign root = res_s[NS-1][cwun_pkg::ROOT_W-1:0];
	assign side_out = side_s[NS-1];
endmodule

[sv/cwun_div_pipe.sv]
// pair of pipelined restoring dividers sharing one divisor
// depends on cwun_pkg
`timescale 1ns / 1ps
module cwun_div_pipe (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [cwun_pkg::NUM_W-1:0]     num_x,
	input  logic [cwun_pkg::NUM_W-1:0]     num_y,
	input  logic [cwun_pkg::ROOT_W-1:0]    den,
	input  cwun_pkg::cwun_side_t           side_in,
	output logic [cwun_pkg::Q_W-1:0]       quot_x,
	output logic [cwun_pkg::Q_W-1:0]       quot_y,
	output cwun_pkg::cwun_side_t           side_out
);
	localparam int DW = cwun_pkg::DIV_W;
	localparam int QW = cwun_pkg::Q_W;
	localparam int NS = cwun_pkg::DIV_STAGES;
	localparam int PS = cwun_pkg::DIV_PER_STAGE;

	logic [DW-1:0] rx_s [NS];
	logic [DW-1:0] ry_s [NS];
	logic [QW-1:0] qx_s [NS];
	logic [QW-1:0] qy_s [NS];
	logic [cwun_pkg::ROOT_W-1:0] d_s [NS];
	cwun_pkg::cwun_side_t side_s [NS];
	logic [DW-1:0] rx_in [NS];
	logic [DW-1:0] ry_in [NS];
	logic [QW-1:0] qx_in [NS];
	logic [QW-1:0] qy_in [NS];
	logic [cwun_pkg::ROOT_W-1:0] d_in [NS];
	cwun_pkg::cwun_side_t sd_in [NS];
	logic [DW-1:0] rx_nx [NS];
	logic [DW-1:0] ry_nx [NS];
	logic [QW-1:0] qx_nx [NS];
	logic [QW-1:0] qy_nx [NS];

	genvar g;
	for (g = 0; g < NS; g++) begin : g_stage
		if (g == 0) begin : g_first
			assign rx_in[g] = DW'(num_x);
			assign ry_in[g] = DW'(num_y);
			assign qx_in[g] = '0;
			assign qy_in[g] = '0;
			assign d_in[g] = den;
			assign sd_in[g] = side_in;
		end else begin : g_next
			assign rx_in[g] = rx_s[g-1];
			assign ry_in[g] = ry_s[g-1];
			assign qx_in[g] = qx_s[g-1];
			assign qy_in[g] = qy_s[g-1];
			assign d_in[g] = d_s[g-1];
			assign sd_in[g] = side_s[g-1];
		end

		always_comb begin
			logic [DW-1:0] rx;
			logic [DW-1:0] ry;
			logic [QW-1:0] qx;
			logic [QW-1:0] qy;
			logic [DW-1:0] dd;
			rx = rx_in[g];
			ry = ry_in[g];
			qx = qx_in[g];
			qy = qy_in[g];
			dd = '0;
			for (int i = 0; i < PS; i++) begin
				if (g * PS + i < QW) begin
					dd = DW'(d_in[g]) << (QW - 1 - (g * PS + i));
					if (rx >= dd) begin
						rx = rx - dd;
						qx = {qx[QW-2:0], 1'b1};
					end else begin
						qx = {qx[QW-2:0], 1'b0};
					end
					if (ry >= dd) begin
						ry = ry - dd;
						qy = {qy[QW-2:0], 1'b1};
					end else begin
						qy = {qy[QW-2:0], 1'b0};
					end
				end
			end
			rx_nx[g] = rx;
			ry_nx[g] = ry;
			qx_nx[g] = qx;
			qy_nx[g] = qy;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[g] <= '0;
			end else begin
				side_s[g] <= sd_in[g];
			end
		end

		always_ff @(posedge clk) begin
			rx_s[g] <= rx_nx[g];
			ry_s[g] <= ry_nx[g];
			qx_s[g] <= qx_nx[g];
			qy_s[g] <= qy_nx[g];
			d_s[g] <= d_in[g];
		end
	end

	assign quot_x = qx_s[NS-1];
	assign quot_y = qy_s[NS-1];
	assign side_out = side_s[NS-1];
endmodule

[sv/cubic_wall_unit_normal.sv]
// top level: unit normal of a curved wall face at one flux point
// depends on cwun_pkg, cwun_isqrt_pipe, cwun_div_pipe, cubic_wall_unit_normal_assert.svh
//
// Fully pipelined: one item is taken in every clock cycle and busy stays low.
// Each result reaches done through the stages named below, among them the sixteen
// square-root stages and eight divider stages.
// Results are shown for one cycle only; the receiver cannot hold them off.
`timescale 1ns / 1ps
`include "cubic_wall_unit_normal_assert.svh"
module cubic_wall_unit_normal (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [cwun_pkg::COORD_WIDTH-1:0] left_x,
	input  logic signed [cwun_pkg::COORD_WIDTH-1:0] left_y,
	input  logic signed [cwun_pkg::COORD_WIDTH-1:0] start_x,
	input  logic signed [cwun_pkg::COORD_WIDTH-1:0] start_y,
	input  logic signed [cwun_pkg::COORD_WIDTH-1:0] end_x,
	input  logic signed [cwun_pkg::COORD_WIDTH-1:0] end_y,
	input  logic signed [cwun_pkg::COORD_WIDTH-1:0] right_x,
	input  logic signed [cwun_pkg::COORD_WIDTH-1:0] right_y,
	input  logic                                   left_present,
	input  logic                                   right_present,
	input  logic signed [cwun_pkg::K_WIDTH-1:0]    local_coord,
	output logic                                   done,
	output logic signed [cwun_pkg::OUT_WIDTH-1:0]  normal_x,
	output logic signed [cwun_pkg::OUT_WIDTH-1:0]  normal_y,
	output logic                                   degenerate
);
	localparam int PT_W = cwun_pkg::PT_W;
	localparam int W_W = cwun_pkg::W_W;
	localparam int LO_W = cwun_pkg::LO_W;
	localparam int HI_W = cwun_pkg::HI_W;
	localparam int LP_W = cwun_pkg::LP_W;
	localparam int HP_W = cwun_pkg::HP_W;
	localparam int T_W = cwun_pkg::T_W;
	localparam int EX_W = cwun_pkg::EX_W;
	localparam int M_W = cwun_pkg::M_W;
	localparam int NM_W = cwun_pkg::NM_W;
	localparam int SPLIT = cwun_pkg::STEP_SPLIT;
	localparam int QW = cwun_pkg::Q_W;
	localparam int OW = cwun_pkg::O_W;
	localparam int FB = cwun_pkg::NORMAL_FRAC_BITS;
	localparam logic signed [W_W-1:0] ONE_Q28 = W_W'(1) <<< 28;
	localparam logic signed [EX_W-1:0] EXACT_LIM = EX_W'(1) <<< cwun_pkg::EXACT_BITS;
	localparam logic [QW-1:0] Q_LIM = QW'(1) << FB;

	assign busy = 1'b0;

	// stage 1: missing neighbours, ksi squared
	logic v_s1;
	logic signed [PT_W-1:0] px_s1 [4];
	logic signed [PT_W-1:0] py_s1 [4];
	logic signed [cwun_pkg::K_WIDTH-1:0] k_s1;
	logic signed [31:0] k2_s1;
	logic signed [PT_W-1:0] px_in [4];
	logic signed [PT_W-1:0] py_in [4];

	always_comb begin
		px_in[0] = PT_W'(left_x);
		px_in[1] = PT_W'(start_x);
		px_in[2] = PT_W'(end_x);
		px_in[3] = PT_W'(right_x);
		py_in[0] = PT_W'(left_y);
		py_in[1] = PT_W'(start_y);
		py_in[2] = PT_W'(end_y);
		py_in[3] = PT_W'(right_y);
		if (!left_present && !right_present) begin
			px_in[0] = (px_in[1] <<< 1) - px_in[2];
			py_in[0] = (py_in[1] <<< 1) - py_in[2];
			px_in[3] = (px_in[2] <<< 1) - px_in[1];
			py_in[3] = (py_in[2] <<< 1) - py_in[1];
		end else if (!left_present) begin
			px_in[0] = (px_in[1] <<< 1) + px_in[1] - (px_in[2] <<< 1) - px_in[2] + px_in[3];
			py_in[0] = (py_in[1] <<< 1) + py_in[1] - (py_in[2] <<< 1) - py_in[2] + py_in[3];
		end else if (!right_present) begin
			px_in[3] = (px_in[2] <<< 1) + px_in[2] - (px_in[1] <<< 1) - px_in[1] + px_in[0];
			py_in[3] = (py_in[2] <<< 1) + py_in[2] - (py_in[1] <<< 1) - py_in[1] + py_in[0];
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= px_in;
		py_s1 <= py_in;
		k_s1 <= local_coord;
		k2_s1 <= 32'(local_coord) * 32'(local_coord);
	end

	// stage 2: shape derivative weights
	logic v_s2;
	logic signed [W_W-1:0] w_s2 [4];
	logic signed [PT_W-1:0] px_s2 [4];
	logic signed [PT_W-1:0] py_s2 [4];
	logic signed [W_W-1:0] kk;
	logic signed [W_W-1:0] k2e;
	logic signed [W_W-1:0] k6;
	logic signed [W_W-1:0] k2x3;

	assign kk = W_W'(k_s1);
	assign k2e = W_W'(k2_s1);
	assign k6 = (kk <<< 16) + (kk <<< 15);
	assign k2x3 = (k2e <<< 1) + k2e;

	always_ff @(posedge clk) begin
		w_s2[0] <= -(ONE_Q28 <<< 1) + k6 - k2x3;
		w_s2[1] <= -((ONE_Q28 <<< 1) + ONE_Q28) - (k6 <<< 1) + (k2e <<< 3) + k2e;
		w_s2[2] <= (ONE_Q28 <<< 2) + (ONE_Q28 <<< 1) + k6 - (k2e <<< 3) - k2e;
		w_s2[3] <= -ONE_Q28 + k2x3;
		px_s2 <= px_s1;
		py_s2 <= py_s1;
	end

	// stage 3: split products
	logic v_s3;
	logic signed [LP_W-1:0] lpx_s3 [4];
	logic signed [LP_W-1:0] lpy_s3 [4];
	logic signed [HP_W-1:0] hpx_s3 [4];
	logic signed [HP_W-1:0] hpy_s3 [4];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			lpx_s3[i] <= LP_W'(w_s2[i]) * LP_W'($signed({1'b0, px_s2[i][LO_W-1:0]}));
			lpy_s3[i] <= LP_W'(w_s2[i]) * LP_W'($signed({1'b0, py_s2[i][LO_W-1:0]}));
			hpx_s3[i] <= HP_W'(w_s2[i]) * HP_W'($signed(px_s2[i][PT_W-1:LO_W]));
			hpy_s3[i] <= HP_W'(w_s2[i]) * HP_W'($signed(py_s2[i][PT_W-1:LO_W]));
		end
	end

	// stage 4: pair sums, stage 5: tangent
	logic v_s4;
	logic v_s5;
	logic signed [T_W-1:0] trm_x [4];
	logic signed [T_W-1:0] trm_y [4];
	logic signed [T_W-1:0] sax_s4, sbx_s4, say_s4, sby_s4;
	logic signed [T_W-1:0] tx_s5, ty_s5;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			trm_x[i] = (T_W'(hpx_s3[i]) <<< LO_W) + T_W'(lpx_s3[i]);
			trm_y[i] = (T_W'(hpy_s3[i]) <<< LO_W) + T_W'(lpy_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		sax_s4 <= trm_x[0] + trm_x[1];
		sbx_s4 <= trm_x[2] + trm_x[3];
		say_s4 <= trm_y[0] + trm_y[1];
		sby_s4 <= trm_y[2] + trm_y[3];
		tx_s5 <= sax_s4 + sbx_s4;
		ty_s5 <= say_s4 + sby_s4;
	end

	// stage 6: exact or coarse tangent, magnitudes and signs
	logic v_s6;
	logic [M_W-1:0] ma_s6, mb_s6;
	logic zero_s6, apos_s6, bneg_s6;
	logic signed [EX_W-1:0] hxe, hye;
	logic exact;
	logic signed [T_W-1:0] av, bv;

	assign hxe = EX_W'($signed(tx_s5[T_W-1:cwun_pkg::LIMB_BITS]));
	assign hye = EX_W'($signed(ty_s5[T_W-1:cwun_pkg::LIMB_BITS]));
	assign exact = (hxe > -EXACT_LIM) && (hxe < EXACT_LIM) && (hye > -EXACT_LIM)
		&& (hye < EXACT_LIM);
	assign av = exact ? tx_s5 : T_W'($signed(tx_s5[T_W-1:cwun_pkg::LIMB_BITS]));
	assign bv = exact ? ty_s5 : T_W'($signed(ty_s5[T_W-1:cwun_pkg::LIMB_BITS]));

	always_ff @(posedge clk) begin
		ma_s6 <= av[T_W-1] ? M_W'(-av) : M_W'(av);
		mb_s6 <= bv[T_W-1] ? M_W'(-bv) : M_W'(bv);
		zero_s6 <= (tx_s5 == '0) && (ty_s5 == '0);
		apos_s6 <= !av[T_W-1] && (av != '0);
		bneg_s6 <= bv[T_W-1];
	end

	// stage 7: larger magnitude
	logic v_s7;
	logic [M_W-1:0] ma_s7, mb_s7, m_s7;
	logic zero_s7, apos_s7, bneg_s7;

	always_ff @(posedge clk) begin
		ma_s7 <= ma_s6;
		mb_s7 <= mb_s6;
		m_s7 <= (ma_s6 > mb_s6) ? ma_s6 : mb_s6;
		zero_s7 <= zero_s6;
		apos_s7 <= apos_s6;
		bneg_s7 <= bneg_s6;
	end

	// stages 8 and 9: right normalize, stages 10 and 11: left normalize
	logic v_s8, v_s9, v_s10, v_s11;
	logic [M_W-1:0] ma_s8, mb_s8, m_s8;
	logic [NM_W-1:0] ma_s9, mb_s9, m_s9;
	logic [NM_W-1:0] ma_s10, mb_s10, m_s10;
	logic [NM_W-1:0] ma_s11, mb_s11;
	logic [M_W-1:0] ra8, rb8, rm8, ra9, rb9, rm9;
	logic [NM_W-1:0] la10, lb10, lm10, la11, lb11, lm11;
	logic zero_s8, apos_s8, bneg_s8, zero_s9, apos_s9, bneg_s9;
	logic zero_s10, apos_s10, bneg_s10, zero_s11, apos_s11, bneg_s11;

	always_comb begin
		ra8 = ma_s7;
		rb8 = mb_s7;
		rm8 = m_s7;
		for (int j = cwun_pkg::RS_STEPS - 1; j >= SPLIT; j--) begin
			if ((rm8 >> ((1 << j) + NM_W - 1)) != '0) begin
				ra8 = ra8 >> (1 << j);
				rb8 = rb8 >> (1 << j);
				rm8 = rm8 >> (1 << j);
			end
		end
		ra9 = ma_s8;
		rb9 = mb_s8;
		rm9 = m_s8;
		for (int j = SPLIT - 1; j >= 0; j--) begin
			if ((rm9 >> ((1 << j) + NM_W - 1)) != '0) begin
				ra9 = ra9 >> (1 << j);
				rb9 = rb9 >> (1 << j);
				rm9 = rm9 >> (1 << j);
			end
		end
		la10 = ma_s9;
		lb10 = mb_s9;
		lm10 = m_s9;
		for (int j = cwun_pkg::LS_STEPS - 1; j >= SPLIT; j--) begin
			if ((lm10 >> (NM_W - (1 << j))) == '0) begin
				la10 = la10 << (1 << j);
				lb10 = lb10 << (1 << j);
				lm10 = lm10 << (1 << j);
			end
		end
		la11 = ma_s10;
		lb11 = mb_s10;
		lm11 = m_s10;
		for (int j = SPLIT - 1; j >= 0; j--) begin
			if ((lm11 >> (NM_W - (1 << j))) == '0) begin
				la11 = la11 << (1 << j);
				lb11 = lb11 << (1 << j);
				lm11 = lm11 << (1 << j);
			end
		end
	end

	always_ff @(posedge clk) begin
		ma_s8 <= ra8;
		mb_s8 <= rb8;
		m_s8 <= rm8;
		ma_s9 <= ra9[NM_W-1:0];
		mb_s9 <= rb9[NM_W-1:0];
		m_s9 <= rm9[NM_W-1:0];
		ma_s10 <= la10;
		mb_s10 <= lb10;
		m_s10 <= lm10;
		ma_s11 <= la11;
		mb_s11 <= lb11;
		{zero_s8, apos_s8, bneg_s8} <= {zero_s7, apos_s7, bneg_s7};
		{zero_s9, apos_s9, bneg_s9} <= {zero_s8, apos_s8, bneg_s8};
		{zero_s10, apos_s10, bneg_s10} <= {zero_s9, apos_s9, bneg_s9};
		{zero_s11, apos_s11, bneg_s11} <= {zero_s10, apos_s10, bneg_s10};
	end

	// stage 12: squares, stage 13: sum of squares
	logic v_s12, v_s13;
	logic [2*NM_W-1:0] sqa_s12, sqb_s12;
	logic [NM_W-1:0] ma_s12, mb_s12, ma_s13, mb_s13;
	logic zero_s12, apos_s12, bneg_s12, zero_s13, apos_s13, bneg_s13;
	logic [cwun_pkg::SQ_W-1:0] sum_s13;

	always_ff @(posedge clk) begin
		sqa_s12 <= (2*NM_W)'(ma_s11) * (2*NM_W)'(ma_s11);
		sqb_s12 <= (2*NM_W)'(mb_s11) * (2*NM_W)'(mb_s11);
		ma_s12 <= ma_s11;
		mb_s12 <= mb_s11;
		{zero_s12, apos_s12, bneg_s12} <= {zero_s11, apos_s11, bneg_s11};
		sum_s13 <= cwun_pkg::SQ_W'(sqa_s12) + cwun_pkg::SQ_W'(sqb_s12);
		ma_s13 <= ma_s12;
		mb_s13 <= mb_s12;
		{zero_s13, apos_s13, bneg_s13} <= {zero_s12, apos_s12, bneg_s12};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
			{v_s8, v_s9, v_s10, v_s11, v_s12, v_s13} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <=
				{start && !busy, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6};
			{v_s8, v_s9, v_s10, v_s11, v_s12, v_s13} <= {v_s7, v_s8, v_s9, v_s10, v_s11, v_s12};
		end
	end

	// length
	cwun_pkg::cwun_side_t sq_side;
	cwun_pkg::cwun_side_t rt_side;
	logic [cwun_pkg::ROOT_W-1:0] len;

	assign sq_side = '{valid: v_s13, zero: zero_s13, a_pos: apos_s13, b_neg: bneg_s13,
		ma: ma_s13, mb: mb_s13};

	cwun_isqrt_pipe u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.x(sum_s13),
		.side_in(sq_side),
		.root(len),
		.side_out(rt_side)
	);

	// stage 30: rounded numerators
	cwun_pkg::cwun_side_t side_s30;
	logic [cwun_pkg::NUM_W-1:0] numx_s30, numy_s30;
	logic [cwun_pkg::ROOT_W-1:0] den_s30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s30 <= '0;
		end else begin
			side_s30 <= rt_side;
		end
	end

	always_ff @(posedge clk) begin
		numx_s30 <= (cwun_pkg::NUM_W'(rt_side.mb) << FB) + cwun_pkg::NUM_W'(len >> 1);
		numy_s30 <= (cwun_pkg::NUM_W'(rt_side.ma) << FB) + cwun_pkg::NUM_W'(len >> 1);
		den_s30 <= len;
	end

	// quotients
	cwun_pkg::cwun_side_t dv_side;
	logic [QW-1:0] qx, qy;

	cwun_div_pipe u_div (
		.clk(clk),
		.arst_n(arst_n),
		.num_x(numx_s30),
		.num_y(numy_s30),
		.den(den_s30),
		.side_in(side_s30),
		.quot_x(qx),
		.quot_y(qy),
		.side_out(dv_side)
	);

	// stage 39: saturate, sign, output
	logic v_s39;
	logic [cwun_pkg::OUT_WIDTH-1:0] nx_s39, ny_s39;
	logic dg_s39;
	logic [QW-1:0] qxs, qys;
	logic signed [OW-1:0] ex, ey, sx, sy;

	assign qxs = (qx > Q_LIM) ? Q_LIM : qx;
	assign qys = (qy > Q_LIM) ? Q_LIM : qy;
	assign ex = $signed(OW'(qxs));
	assign ey = $signed(OW'(qys));
	assign sx = dv_side.b_neg ? -ex : ex;
	assign sy = dv_side.a_pos ? -ey : ey;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s39 <= 1'b0;
		end else begin
			v_s39 <= dv_side.valid;
		end
	end

	always_ff @(posedge clk) begin
		nx_s39 <= dv_side.zero ? '0 : sx[cwun_pkg::OUT_WIDTH-1:0];
		ny_s39 <= dv_side.zero ? '0 : sy[cwun_pkg::OUT_WIDTH-1:0];
		dg_s39 <= dv_side.zero;
	end

	assign done = v_s39;
	assign normal_x = nx_s39;
	assign normal_y = ny_s39;
	assign degenerate = dg_s39;

	`CWUN_ASSERT_DELAY(a_latency, start && !busy, cwun_pkg::LATENCY, done)
	`CWUN_ASSERT_IMPL(a_degen_zero, done && degenerate, normal_x == '0 && normal_y == '0)
	`CWUN_ASSERT_IMPL(a_len_nonzero, side_s30.valid && !side_s30.zero, den_s30 != '0)
endmodule

[dv/testbench.sv]
// self-checking bench for cubic_wall_unit_normal: directed and random node sets, random gaps
// depends on cwun_pkg and the cubic_wall_unit_normal rtl
`timescale 1ns / 1ps
module testbench;

	typedef struct packed {
		logic [cwun_pkg::OUT_WIDTH-1:0] nx;
		logic [cwun_pkg::OUT_WIDTH-1:0] ny;
		logic deg;
	} normal_t;

	class normal_board;
		normal_t pending[$];
		int mismatches;
		int checked;
		int degenerates;

		function new();
			mismatches = 0;
			checked = 0;
			degenerates = 0;
		endfunction

		function longint unsigned root_floor(longint unsigned x);
			longint unsigned res;
			longint unsigned bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > x)
				bitv = bitv >> 2;
			while (bitv != 0) begin
				if (x >= res + bitv) begin
					x = x - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
			return res;
		endfunction

		function normal_t wall_normal(logic signed [cwun_pkg::COORD_WIDTH-1:0] c[8], bit lp,
				bit rp, logic signed [cwun_pkg::K_WIDTH-1:0] ksi);
			logic signed [127:0] px[4];
			logic signed [127:0] py[4];
			logic signed [127:0] w[4];
			logic signed [127:0] kk, tx, ty, a, b, hx, hy;
			logic [127:0] ma, mb, m, qx, qy, len;
			normal_t r;
			for (int i = 0; i < 4; i++) begin
				px[i] = c[2*i];
				py[i] = c[2*i+1];
			end
			if (!lp && !rp) begin
				px[0] = 2 * px[1] - px[2];
				py[0] = 2 * py[1] - py[2];
				px[3] = 2 * px[2] - px[1];
				py[3] = 2 * py[2] - py[1];
			end else if (!lp) begin
				px[0] = 3 * px[1] - 3 * px[2] + px[3];
				py[0] = 3 * py[1] - 3 * py[2] + py[3];
			end else if (!rp) begin
				px[3] = 3 * px[2] - 3 * px[1] + px[0];
				py[3] = 3 * py[2] - 3 * py[1] + py[0];
			end
			kk = ksi;
			w[0] = -2 * (128'sd1 <<< 28) + 6 * kk * 16384 - 3 * kk * kk;
			w[1] = -3 * (128'sd1 <<< 28) - 12 * kk * 16384 + 9 * kk * kk;
			w[2] = 6 * (128'sd1 <<< 28) + 6 * kk * 16384 - 9 * kk * kk;
			w[3] = -1 * (128'sd1 <<< 28) + 3 * kk * kk;
			tx = 0;
			ty = 0;
			for (int i = 0; i < 4; i++) begin
				tx = tx + w[i] * px[i];
				ty = ty + w[i] * py[i];
			end
			r = '0;
			if (tx == 0 && ty == 0) begin
				r.deg = 1'b1;
				return r;
			end
			hx = tx >>> 24;
			hy = ty >>> 24;
			if (hx > -(128'sd1 <<< 38) && hx < (128'sd1 <<< 38) &&
					hy > -(128'sd1 <<< 38) && hy < (128'sd1 <<< 38)) begin
				a = tx;
				b = ty;
			end else begin
				a = hx;
				b = hy;
			end
			ma = a < 0 ? -a : a;
			mb = b < 0 ? -b : b;
			m = ma > mb ? ma : mb;
			if (m >= (128'd1 << 31)) begin
				while (m >= (128'd1 << 31)) begin
					m = m >> 1;
					ma = ma >> 1;
					mb = mb >> 1;
				end
			end else begin
				while (m < (128'd1 << 30)) begin
					m = m << 1;
					ma = ma << 1;
					mb = mb << 1;
				end
			end
			len = root_floor(64'(ma * ma + mb * mb));
			qx = ((mb << cwun_pkg::NORMAL_FRAC_BITS) + len / 2) / len;
			qy = ((ma << cwun_pkg::NORMAL_FRAC_BITS) + len / 2) / len;
			if (qx > (128'd1 << cwun_pkg::NORMAL_FRAC_BITS))
				qx = 128'd1 << cwun_pkg::NORMAL_FRAC_BITS;
			if (qy > (128'd1 << cwun_pkg::NORMAL_FRAC_BITS))
				qy = 128'd1 << cwun_pkg::NORMAL_FRAC_BITS;
			r.nx = b < 0 ? -qx[cwun_pkg::OUT_WIDTH-1:0] : qx[cwun_pkg::OUT_WIDTH-1:0];
			r.ny = a > 0 ? -qy[cwun_pkg::OUT_WIDTH-1:0] : qy[cwun_pkg::OUT_WIDTH-1:0];
			return r;
		endfunction

		function void note_item(logic signed [cwun_pkg::COORD_WIDTH-1:0] c[8], bit lp, bit rp,
				logic signed [cwun_pkg::K_WIDTH-1:0] ksi);
			pending.push_back(wall_normal(c, lp, rp, ksi));
		endfunction

		function void check_result(normal_t got);
			normal_t exp_r;
			checked++;
			if (got.deg) degenerates++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result nx=%h ny=%h deg=%b", got.nx, got.ny, got.deg);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp nx=%h ny=%h deg=%b, got nx=%h ny=%h deg=%b",
						exp_r.nx, exp_r.ny, exp_r.deg, got.nx, got.ny, got.deg);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [cwun_pkg::COORD_WIDTH-1:0] left_x, left_y, start_x, start_y;
	logic signed [cwun_pkg::COORD_WIDTH-1:0] end_x, end_y, right_x, right_y;
	logic left_present, right_present;
	logic signed [cwun_pkg::K_WIDTH-1:0] local_coord;
	logic done;
	logic signed [cwun_pkg::OUT_WIDTH-1:0] normal_x, normal_y;
	logic degenerate;

	normal_board board = new();
	int sent;
	int idle_cycles;
	logic signed [cwun_pkg::COORD_WIDTH-1:0] coords[8];

	cubic_wall_unit_normal u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.left_x(left_x), .left_y(left_y), .start_x(start_x), .start_y(start_y),
		.end_x(end_x), .end_y(end_y), .right_x(right_x), .right_y(right_y),
		.left_present(left_present), .right_present(right_present),
		.local_coord(local_coord), .done(done), .normal_x(normal_x),
		.normal_y(normal_y), .degenerate(degenerate)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		logic signed [cwun_pkg::COORD_WIDTH-1:0] c[8];
		logic moved;
		moved = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				c[0] = left_x; c[1] = left_y; c[2] = start_x; c[3] = start_y;
				c[4] = end_x; c[5] = end_y; c[6] = right_x; c[7] = right_y;
				board.note_item(c, left_present, right_present, local_coord);
				moved = 1'b1;
			end
			if (done) begin
				board.check_result({normal_x, normal_y, degenerate});
				moved = 1'b1;
			end
			if (idle_cycles > 3000) begin
				$display("** cubic_wall_unit_normal: FAILED **");
				$finish;
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
		end
	end

	task automatic send_item(logic signed [cwun_pkg::COORD_WIDTH-1:0] c[8], bit lp, bit rp,
			logic signed [cwun_pkg::K_WIDTH-1:0] ksi);
		left_x <= c[0]; left_y <= c[1]; start_x <= c[2]; start_y <= c[3];
		end_x <= c[4]; end_y <= c[5]; right_x <= c[6]; right_y <= c[7];
		left_present <= lp;
		right_present <= rp;
		local_coord <= ksi;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	task automatic idle_for(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic fill_curve(bit wild);
		logic signed [cwun_pkg::COORD_WIDTH-1:0] bx, by;
		int spread;
		bx = $urandom;
		by = $urandom;
		spread = 1 << $urandom_range(0, 24);
		for (int i = 0; i < 4; i++) begin
			if (wild) begin
				coords[2*i] = $urandom;
				coords[2*i+1] = $urandom;
			end else begin
				coords[2*i] = bx + i * $urandom_range(0, spread) - spread / 2;
				coords[2*i+1] = by + $urandom_range(0, spread) - spread / 2;
			end
		end
	endtask

	function automatic logic signed [cwun_pkg::K_WIDTH-1:0] pick_ksi();
		case ($urandom_range(0, 9))
			0: return cwun_pkg::K_WIDTH'($urandom);
			1: return cwun_pkg::K_WIDTH'(-16384);
			2: return cwun_pkg::K_WIDTH'(16384);
			3: return '0;
			default: return cwun_pkg::K_WIDTH'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	initial begin
		int burst;
		logic signed [cwun_pkg::K_WIDTH-1:0] dir_ksi[6];
		sent = 0;
		idle_cycles = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		left_x <= '0; left_y <= '0; start_x <= '0; start_y <= '0;
		end_x <= '0; end_y <= '0; right_x <= '0; right_y <= '0;
		left_present <= 1'b0;
		right_present <= 1'b0;
		local_coord <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: flat, degenerate, extremes, every flag pair, ksi corners
		dir_ksi = '{16'sh0000, -16384, 16384, 16'sh7fff, 16'sh8000, 8192};
		for (int i = 0; i < 8; i++) coords[i] = 32'sh00010000;
		send_item(coords, 1, 1, 0);
		send_item(coords, 0, 0, 16384);
		for (int f = 0; f < 4; f++) begin
			for (int i = 0; i < 4; i++) begin
				coords[2*i] = i << 16;
				coords[2*i+1] = (f == 1) ? -(i << 16) : (i * i) << 14;
			end
			send_item(coords, f[0], f[1], dir_ksi[f]);
		end
		for (int i = 0; i < 8; i++) coords[i] = i[0] ? 32'sh7fffffff : 32'sh80000000;
		for (int f = 0; f < 4; f++) send_item(coords, f[0], f[1], dir_ksi[f + 2]);
		for (int i = 0; i < 8; i++) coords[i] = (i / 2) % 2 ? 32'sh7fffffff : 32'sh80000000;
		for (int f = 0; f < 4; f++) send_item(coords, f[0], f[1], dir_ksi[5 - f]);
		for (int i = 0; i < 8; i++) coords[i] = i[0] ? 32'sh00000000 : 32'shffffffff;
		send_item(coords, 1, 0, 16'sh7fff);
		send_item(coords, 0, 1, 16'sh8000);
		for (int i = 0; i < 8; i++) coords[i] = i[0] ? (i << 20) : 32'sh7fffffff;
		send_item(coords, 1, 1, 4096);
		send_item(coords, 0, 0, -4096);
		idle_for(1);

		// random bursts
		while (sent < 1775) begin
			burst = $urandom_range(1, 40);
			for (int j = 0; j < burst; j++) begin
				fill_curve($urandom_range(0, 4) == 0);
				if ($urandom_range(0, 30) == 0)
					for (int i = 2; i < 8; i++) coords[i] = coords[i % 2];
				send_item(coords, 1'($urandom), 1'($urandom), pick_ksi());
			end
			if (sent > 900 && sent < 950) begin
				start <= 1'b0;
				@(posedge clk);
				while (board.pending.size() != 0) @(posedge clk);
			end else if ($urandom_range(0, 3) != 0) begin
				idle_for($urandom_range(1, 8));
			end
		end
		start <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (cwun_pkg::LATENCY + 10) @(posedge clk);

		$display("items sent %0d, results checked %0d, degenerate %0d, mismatches %0d",
			sent, board.checked, board.degenerates, board.mismatches);
		if (board.mismatches == 0 && board.pending.size() == 0 && board.checked == sent) begin
			$display("** cubic_wall_unit_normal: PASSED **");
		end else begin
			$display("** cubic_wall_unit_normal: FAILED **");
		end
		$finish;
	end
endmodule

[sim.f]
+incdir+sv
sv/cwun_pkg.sv
sv/cwun_isqrt_pipe.sv
sv/cwun_div_pipe.sv
sv/cubic_wall_unit_normal.sv
dv/testbench.sv
